[src/frie_pkg.sv]
// ----------------------------------------------------------------------------
// frie_pkg: shared types and constants
// Operation, operand kind and status codes, and the item types of both
// channels of the instruction executor.
// ----------------------------------------------------------------------------
package frie_pkg;

  localparam int DefNumRegs   = 4;
  localparam int DefMemWords  = 64;
  localparam int DefDataWidth = 32;
  localparam int BytesPerWord = 4;
  localparam int ShownRegs    = 4;
  localparam int OutWidth     = 32;
  localparam int ValWidth     = 31;

  localparam logic [2:0] OP_MOV  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_EXIT = 3'd5;

  localparam logic [1:0] K_REG   = 2'd0;
  localparam logic [1:0] K_CONST = 2'd1;
  localparam logic [1:0] K_ADDR  = 2'd2;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_DIVZERO  = 3'd1;
  localparam logic [2:0] ST_EXIT_OK  = 3'd2;
  localparam logic [2:0] ST_EXIT_ERR = 3'd3;
  localparam logic [2:0] ST_ILLEGAL  = 3'd4;
  localparam logic [2:0] ST_BADADDR  = 3'd5;
  localparam logic [2:0] ST_HALTED   = 3'd6;

  // Input item: one decoded instruction.
  typedef struct packed {
    logic [2:0]          operation;
    logic [1:0]          first_kind;
    logic [ValWidth-1:0] first_value;
    logic [1:0]          second_kind;
    logic [ValWidth-1:0] second_value;
  } in_item_t;

  // Result item: status and the visible registers.
  typedef struct packed {
    logic [2:0]                 status;
    logic signed [OutWidth-1:0] reg_zero;
    logic signed [OutWidth-1:0] reg_one;
    logic signed [OutWidth-1:0] reg_two;
    logic signed [OutWidth-1:0] reg_three;
  } out_item_t;

  // Classified command handed from front to back.
  typedef enum logic [2:0] {
    CMD_STATUS,   // no change, report status only
    CMD_MOVR,     // register <- register
    CMD_MOVC,     // register <- constant
    CMD_LOAD,     // register <- memory
    CMD_STORE,    // memory <- register
    CMD_ARITH,    // add, sub, mul or div
    CMD_EXIT      // halt
  } cmd_t;

endpackage

[src/frie_front.sv]
// ----------------------------------------------------------------------------
// frie_front: instruction classifier
// Checks operand forms, register numbers and addresses, and turns each
// item into a command for the back end.
// ----------------------------------------------------------------------------
module frie_front import frie_pkg::*; #(
  parameter int NUM_REGS  = DefNumRegs,
  parameter int MEM_WORDS = DefMemWords,
  parameter int RW = $clog2(NUM_REGS),
  parameter int AW = $clog2(MEM_WORDS)
) (
  input  in_item_t              item,
  output cmd_t                  cmd,
  output logic [2:0]            op,
  output logic [2:0]            status,
  output logic [RW-1:0]         dst,
  output logic [RW-1:0]         src,
  output logic [AW-1:0]         addr,
  output logic [ValWidth-1:0]   cval
);

  logic r1_ok, r2_ok, a1_ok, a2_ok;

  // Range checks on both operands.
  always_comb begin
    r1_ok = 32'(item.first_value) < 32'(NUM_REGS);
    r2_ok = 32'(item.second_value) < 32'(NUM_REGS);
    a1_ok = (item.first_value[1:0] == 2'b00) &&
            (32'(item.first_value >> 2) < 32'(MEM_WORDS));
    a2_ok = (item.second_value[1:0] == 2'b00) &&
            (32'(item.second_value >> 2) < 32'(MEM_WORDS));
  end

  // Classification of the instruction.
  always_comb begin
    cmd    = CMD_STATUS;
    status = ST_ILLEGAL;
    op     = item.operation;
    dst    = item.first_value[RW-1:0];
    src    = item.second_value[RW-1:0];
    addr   = item.second_value[AW+1:2];
    cval   = item.second_value;
    case (item.operation)
      OP_EXIT: begin
        if (item.first_kind == K_CONST && item.first_value <= ValWidth'(1)) begin
          cmd    = CMD_EXIT;
          status = item.first_value[0] ? ST_EXIT_ERR : ST_EXIT_OK;
        end
      end
      OP_MOV: begin
        if (item.first_kind == K_REG) begin
          if (r1_ok) begin
            case (item.second_kind)
              K_REG: begin
                if (r2_ok) begin
                  cmd = CMD_MOVR; status = ST_DONE;
                end
              end
              K_CONST: begin
                cmd = CMD_MOVC; status = ST_DONE;
              end
              K_ADDR: begin
                if (a2_ok) begin
                  cmd = CMD_LOAD; status = ST_DONE;
                end else begin
                  status = ST_BADADDR;
                end
              end
              default: status = ST_ILLEGAL;
            endcase
          end
        end else if (item.first_kind == K_ADDR) begin
          src  = item.second_value[RW-1:0];
          addr = item.first_value[AW+1:2];
          if (item.second_kind == K_REG && r2_ok) begin
            if (a1_ok) begin
              cmd = CMD_STORE; status = ST_DONE;
            end else begin
              status = ST_BADADDR;
            end
          end
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (item.first_kind == K_REG && item.second_kind == K_REG && r1_ok && r2_ok) begin
          cmd = CMD_ARITH; status = ST_DONE;
        end
      end
      default: status = ST_ILLEGAL;
    endcase
  end

endmodule

[src/frie_queue.sv]
// ----------------------------------------------------------------------------
// frie_queue: two-entry command queue
// Decouples the classifier from the execution unit.
// ----------------------------------------------------------------------------
module frie_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  logic [W-1:0] slots [2];
  logic         wptr, rptr;
  logic [1:0]   count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = slots[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

endmodule

[src/frie_back.sv]
// ----------------------------------------------------------------------------
// frie_back: execution unit
// Holds the register file, the data memory and the halt flag, carries out
// commands with a bit-serial divider, and presents one result per item.
// ----------------------------------------------------------------------------
module frie_back import frie_pkg::*; #(
  parameter int NUM_REGS   = DefNumRegs,
  parameter int MEM_WORDS  = DefMemWords,
  parameter int DATA_WIDTH = DefDataWidth,
  parameter int RW = $clog2(NUM_REGS),
  parameter int AW = $clog2(MEM_WORDS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  cmd_t                cmd,
  input  logic [2:0]          op,
  input  logic [2:0]          cstatus,
  input  logic [RW-1:0]       dst,
  input  logic [RW-1:0]       src,
  input  logic [AW-1:0]       addr,
  input  logic [ValWidth-1:0] cval,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  output logic                clearing
);

  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_DFIN, S_OUT
  } state_t;

  state_t            state;
  logic [DW-1:0]     regs [NUM_REGS];
  logic [DW-1:0]     mem [MEM_WORDS];
  logic              halted;
  logic [AW:0]       clr_idx;
  logic [DW-1:0]     mem_q;
  logic [DW-1:0]     opa, opb;
  logic [DW-1:0]     prod;
  logic [DW-1:0]     rem, quo, divisor;
  logic [CW-1:0]     cnt;
  logic              qneg;
  logic [2:0]        st;
  cmd_t              c_cmd;
  logic [2:0]        c_op;
  logic [RW-1:0]     c_dst, c_src;
  logic [AW-1:0]     c_addr;
  logic [ValWidth-1:0] c_val;
  logic [DW:0]       trial;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DW-1:0]     mem_wd;

  assign cmd_pop   = (state == S_IDLE) && cmd_valid;
  assign out_valid = state == S_OUT;
  assign clearing  = state == S_CLEAR;
  assign trial     = {rem, quo[DW-1]} - {1'b0, divisor};

  // Result fields: registers that do not exist read zero.
  always_comb begin
    logic [OutWidth-1:0] v [ShownRegs];
    for (int k = 0; k < ShownRegs; k++) begin
      v[k] = '0;
      if (k < NUM_REGS) v[k] = OutWidth'($signed(regs[k]));
    end
    out_item.status    = st;
    out_item.reg_zero  = v[0];
    out_item.reg_one   = v[1];
    out_item.reg_two   = v[2];
    out_item.reg_three = v[3];
  end

  // Memory write port: clearing pass or store.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = c_addr;
    mem_wd = regs[c_src];
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_idx[AW-1:0];
      mem_wd = '0;
    end else if (state == S_EXEC && c_cmd == CMD_STORE) begin
      mem_we = 1'b1;
    end
  end

  // Data memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[c_addr];
  end

  // Sequencer, register file and divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      halted  <= 1'b0;
      for (int k = 0; k < NUM_REGS; k++) regs[k] <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + (AW+1)'(1);
          if (clr_idx == (AW+1)'(MEM_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            c_cmd <= cmd; c_op <= op;
            c_dst <= dst; c_src <= src; c_addr <= addr; c_val <= cval;
            if (halted) begin
              st    <= ST_HALTED;
              state <= S_OUT;
            end else begin
              st    <= cstatus;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // Operands fetched; memory read settles in this cycle.
          opa   <= regs[c_dst];
          opb   <= regs[c_src];
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_OUT;
          case (c_cmd)
            CMD_MOVR:  regs[c_dst] <= regs[c_src];
            CMD_MOVC:  regs[c_dst] <= DW'({{(DW > ValWidth ? DW - ValWidth : 1){1'b0}}, c_val});
            CMD_LOAD:  regs[c_dst] <= mem_q;
            CMD_EXIT:  halted <= 1'b1;
            CMD_ARITH: begin
              case (c_op)
                OP_ADD: regs[c_dst] <= opa + opb;
                OP_SUB: regs[c_dst] <= opa - opb;
                OP_MUL: regs[c_dst] <= prod;
                default: begin
                  if (opb == '0) begin
                    st <= ST_DIVZERO;
                  end else begin
                    quo     <= opa[DW-1] ? -opa : opa;
                    divisor <= opb[DW-1] ? -opb : opb;
                    qneg    <= opa[DW-1] ^ opb[DW-1];
                    rem     <= '0;
                    cnt     <= CW'(DW);
                    state   <= S_DIV;
                  end
                end
              endcase
            end
            default: ;
          endcase
        end
        S_DIV: begin
          // One quotient bit per cycle, restoring.
          if (!trial[DW]) begin
            rem <= trial[DW-1:0];
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= {rem[DW-2:0], quo[DW-1]};
            quo <= {quo[DW-2:0], 1'b0};
          end
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) state <= S_DFIN;
        end
        S_DFIN: begin
          regs[c_dst] <= qneg ? -quo : quo;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Registered product for multiply.
  always_ff @(posedge clk) begin
    prod <= regs[c_dst] * regs[c_src];
  end

endmodule

[src/four_register_instruction_executor_core.sv]
// ----------------------------------------------------------------------------
// four_register_instruction_executor_core: instruction executor top level
// Executes one decoded instruction per input item on a small register
// machine with a byte-addressed data memory.
// ----------------------------------------------------------------------------
// Usage: instructions arrive on the in channel (in_valid / in_ready, payload
// in_item) and each gives exactly one result item on the out channel
// (out_valid / out_ready, payload out_item): a status and registers 0 to 3
// after the instruction. A classifier checks operand forms and addresses and
// pushes a command into a two-entry queue; the execution unit pops it.
// Sequence: each item passes the queue and the IDLE, READ, EXEC and OUT states
// of the execution unit; once halted it goes from IDLE straight to OUT, and
// a divide by a nonzero divisor adds the DIV and DFIN states, in which the
// bit-serial divider produces one quotient bit per cycle. Items are
// executed one at a time, so a new item is popped only after the receiver
// takes the result; the queue takes up to two further items while one is
// in execution. After reset the data memory is cleared, one word per cycle,
// all MEM_WORDS words (64 by default); in_ready stays low meanwhile.
// When the receiver stalls, the result is held and the queue fills, after
// which in_ready falls. After EXIT every item reports the halted status.
// ----------------------------------------------------------------------------
module four_register_instruction_executor_core import frie_pkg::*; #(
  parameter int NUM_REGS   = DefNumRegs,
  parameter int MEM_WORDS  = DefMemWords,
  parameter int DATA_WIDTH = DefDataWidth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int QW = 3 + 3 + 3 + 2 * RW + AW + ValWidth;

  typedef struct packed {
    cmd_t                cmd;
    logic [2:0]          op;
    logic [2:0]          status;
    logic [RW-1:0]       dst;
    logic [RW-1:0]       src;
    logic [AW-1:0]       addr;
    logic [ValWidth-1:0] cval;
  } qcmd_t;

  qcmd_t f_cmd, b_cmd;
  logic  q_full, q_empty, q_pop, clearing, push;

  frie_front #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS), .RW(RW), .AW(AW)) u_front (
    .item(in_item), .cmd(f_cmd.cmd), .op(f_cmd.op), .status(f_cmd.status),
    .dst(f_cmd.dst), .src(f_cmd.src), .addr(f_cmd.addr), .cval(f_cmd.cval)
  );

  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  frie_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(f_cmd), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(b_cmd)
  );

  frie_back #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS), .DATA_WIDTH(DATA_WIDTH),
              .RW(RW), .AW(AW)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(!q_empty), .cmd_pop(q_pop),
    .cmd(b_cmd.cmd), .op(b_cmd.op), .cstatus(b_cmd.status), .dst(b_cmd.dst),
    .src(b_cmd.src), .addr(b_cmd.addr), .cval(b_cmd.cval),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .clearing(clearing)
  );

  // No item is taken while the memory is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready) else $error("item accepted during clear");

  // The queue is never popped while empty.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  // A result and a pop never coincide: one item is executed at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_pop) else $error("pop while result pending");

endmodule

[verif/four_register_instruction_executor_core_test.sv]
// ----------------------------------------------------------------------------
// Instruction executor testbench
// Drives decoded instructions into the executor with random gaps and
// back-pressure. A model of the register machine predicts the status and the
// registers after every item, and each result is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module four_register_instruction_executor_core_test;
  import frie_pkg::*;

  localparam int NumRegs  = DefNumRegs;
  localparam int MemWords = DefMemWords;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Predicted machine state.
  logic [31:0] mach_regs [NumRegs];
  logic [31:0] mach_mem [MemWords];
  bit          mach_halted;

  out_item_t   pending_results [$];
  int          fail_count;
  int          result_count;
  int          div_count;
  int          halt_count;
  bit          stim_done;
  bit          hold_off_rx;
  int          tx_gap_max = 14;
  int          rx_gap_max = 14;

  // Directed rows: expected result only where it is obvious.
  typedef struct {
    in_item_t  item;
    bit        has_fixed;
    out_item_t fixed;
  } row_t;
  row_t directed_rows [$];

  four_register_instruction_executor_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  function automatic in_item_t make_item(logic [2:0] op, logic [1:0] k1, logic [30:0] v1,
                                         logic [1:0] k2, logic [30:0] v2);
    in_item_t it;
    it.operation    = op;
    it.first_kind   = k1;
    it.first_value  = v1;
    it.second_kind  = k2;
    it.second_value = v2;
    return it;
  endfunction

  function automatic bit address_valid(logic [30:0] a);
    return (a % BytesPerWord) == 0 && (a / BytesPerWord) < MemWords;
  endfunction

  // Signed divide truncating toward zero, wrapping on overflow.
  function automatic logic [31:0] divide_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic out_item_t snapshot(logic [2:0] st);
    out_item_t r;
    r.status    = st;
    r.reg_zero  = mach_regs[0];
    r.reg_one   = mach_regs[1];
    r.reg_two   = mach_regs[2];
    r.reg_three = mach_regs[3];
    return r;
  endfunction

  // Execute one instruction on the predicted machine.
  function automatic out_item_t execute_instruction(in_item_t it);
    logic [31:0] a;
    logic [31:0] b;
    logic [30:0] v1;
    logic [30:0] v2;
    v1 = it.first_value;
    v2 = it.second_value;
    if (mach_halted) return snapshot(ST_HALTED);
    if (it.operation == OP_EXIT) begin
      if (it.first_kind != K_CONST || v1 > 1) return snapshot(ST_ILLEGAL);
      mach_halted = 1'b1;
      return snapshot(v1 == 0 ? ST_EXIT_OK : ST_EXIT_ERR);
    end
    if (it.operation == OP_MOV) begin
      if (it.first_kind == K_REG) begin
        if (it.second_kind > K_ADDR || v1 >= NumRegs) return snapshot(ST_ILLEGAL);
        if (it.second_kind == K_REG) begin
          if (v2 >= NumRegs) return snapshot(ST_ILLEGAL);
          mach_regs[v1] = mach_regs[v2];
        end else if (it.second_kind == K_CONST) begin
          mach_regs[v1] = {1'b0, v2};
        end else begin
          if (!address_valid(v2)) return snapshot(ST_BADADDR);
          mach_regs[v1] = mach_mem[v2 / BytesPerWord];
        end
        return snapshot(ST_DONE);
      end
      if (it.first_kind == K_ADDR) begin
        if (it.second_kind != K_REG || v2 >= NumRegs) return snapshot(ST_ILLEGAL);
        if (!address_valid(v1)) return snapshot(ST_BADADDR);
        mach_mem[v1 / BytesPerWord] = mach_regs[v2];
        return snapshot(ST_DONE);
      end
      return snapshot(ST_ILLEGAL);
    end
    if (it.operation > OP_EXIT || it.first_kind != K_REG || it.second_kind != K_REG ||
        v1 >= NumRegs || v2 >= NumRegs)
      return snapshot(ST_ILLEGAL);
    a = mach_regs[v1];
    b = mach_regs[v2];
    case (it.operation)
      OP_ADD: mach_regs[v1] = a + b;
      OP_SUB: mach_regs[v1] = a - b;
      OP_MUL: mach_regs[v1] = a * b;
      default: begin
        if (b == 0) return snapshot(ST_DIVZERO);
        mach_regs[v1] = divide_trunc(a, b);
      end
    endcase
    return snapshot(ST_DONE);
  endfunction

  // Offer one item and wait for it to be taken.
  task automatic send_item(in_item_t it, bit has_fixed, out_item_t fixed);
    out_item_t pred;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = execute_instruction(it);
    if (has_fixed && pred != fixed) begin
      $display("%0t directed row mismatch: table %h, predicted %h", $time, fixed, pred);
      fail_count++;
    end
    pending_results.push_back(has_fixed ? fixed : pred);
    if (it.operation == OP_DIV) div_count++;
  endtask

  task automatic idle_sender();
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [30:0] random_value(logic [1:0] kind);
    case ($urandom_range(9, 0))
      0: return 31'($urandom);
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(7, 0));
      default: begin
        if (kind == K_ADDR) return 31'($urandom_range(MemWords - 1, 0) * BytesPerWord);
        if (kind == K_REG) return 31'($urandom_range(NumRegs - 1, 0));
        return ($urandom_range(1, 0) != 0) ? 31'($urandom) : 31'($urandom_range(20, 0));
      end
    endcase
  endfunction

  // Mostly well-formed instructions, with some noise.
  function automatic in_item_t random_instruction();
    logic [2:0] op;
    logic [1:0] k1;
    logic [1:0] k2;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 85) begin
      op = 3'($urandom_range(4, 0));
      k1 = K_REG;
      k2 = K_REG;
      if (op == OP_MOV) begin
        case ($urandom_range(3, 0))
          0: k2 = K_CONST;
          1: k2 = K_ADDR;
          2: begin k1 = K_ADDR; k2 = K_REG; end
          default: k2 = K_REG;
        endcase
      end
    end else begin
      op = 3'($urandom_range(7, 0));
      k1 = 2'($urandom_range(3, 0));
      k2 = 2'($urandom_range(3, 0));
    end
    return make_item(op, k1, random_value(k1), k2, random_value(k2));
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_item);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status != want.status) begin
          $display("%0t status: expected %0d, actual %0d", $time, want.status, out_item.status);
          fail_count++;
        end
        if (out_item.reg_zero != want.reg_zero) begin
          $display("%0t reg_zero: expected %h, actual %h", $time, want.reg_zero,
                   out_item.reg_zero);
          fail_count++;
        end
        if (out_item.reg_one != want.reg_one) begin
          $display("%0t reg_one: expected %h, actual %h", $time, want.reg_one,
                   out_item.reg_one);
          fail_count++;
        end
        if (out_item.reg_two != want.reg_two) begin
          $display("%0t reg_two: expected %h, actual %h", $time, want.reg_two,
                   out_item.reg_two);
          fail_count++;
        end
        if (out_item.reg_three != want.reg_three) begin
          $display("%0t reg_three: expected %h, actual %h", $time, want.reg_three,
                   out_item.reg_three);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when asked.
  initial begin
    int gap;
    int k;
    @(posedge clk);
    while (!stim_done) begin
      if (hold_off_rx) begin
        out_ready <= 1'b0;
        for (k = 0; k < 300; k++) @(posedge clk);
        hold_off_rx = 1'b0;
      end
      gap = $urandom_range(rx_gap_max, 0);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // Main stimulus.
  initial begin
    out_item_t none;
    row_t      r;
    int        n;
    int        phase;
    none = '0;
    for (int i = 0; i < NumRegs; i++) mach_regs[i] = '0;
    for (int i = 0; i < MemWords; i++) mach_mem[i] = '0;

    // Fixed results taken from reset state and the error rules.
    r.has_fixed = 1'b1;
    r.item = make_item(OP_ADD, K_REG, 0, K_REG, 1);          r.fixed = none;
    directed_rows.push_back(r);
    r.item = make_item(OP_DIV, K_REG, 2, K_REG, 3);
    r.fixed = none; r.fixed.status = ST_DIVZERO;              directed_rows.push_back(r);
    r.item = make_item(OP_MOV, K_CONST, 0, K_REG, 1);
    r.fixed.status = ST_ILLEGAL;                              directed_rows.push_back(r);
    r.item = make_item(3'd6, K_REG, 0, K_REG, 0);             directed_rows.push_back(r);
    r.item = make_item(3'd7, K_REG, 0, K_REG, 0);             directed_rows.push_back(r);
    r.item = make_item(OP_MOV, 2'd3, 0, K_REG, 0);            directed_rows.push_back(r);
    r.item = make_item(OP_MOV, K_REG, 4, K_CONST, 1);         directed_rows.push_back(r);
    r.item = make_item(OP_MOV, K_ADDR, 0, K_ADDR, 4);         directed_rows.push_back(r);
    r.item = make_item(OP_EXIT, K_CONST, 2, K_REG, 0);        directed_rows.push_back(r);
    r.item = make_item(OP_MOV, K_REG, 0, K_ADDR, 2);
    r.fixed.status = ST_BADADDR;                              directed_rows.push_back(r);
    r.item = make_item(OP_MOV, K_ADDR, 256, K_REG, 0);        directed_rows.push_back(r);
    r.item = make_item(OP_MOV, K_ADDR, 31'h7FFF_FFFF, K_REG, 0); directed_rows.push_back(r);
    // Predicted rows: wide constants, arithmetic extremes, memory round trip.
    r.has_fixed = 1'b0;
    r.item = make_item(OP_MOV, K_REG, 0, K_CONST, 31'h7FFF_FFFF); directed_rows.push_back(r);
    r.item = make_item(OP_ADD, K_REG, 0, K_REG, 0);           directed_rows.push_back(r);
    r.item = make_item(OP_MOV, K_REG, 1, K_CONST, 1);         directed_rows.push_back(r);
    r.item = make_item(OP_ADD, K_REG, 0, K_REG, 1);           directed_rows.push_back(r);
    r.item = make_item(OP_SUB, K_REG, 2, K_REG, 1);           directed_rows.push_back(r);
    r.item = make_item(OP_MUL, K_REG, 3, K_REG, 3);           directed_rows.push_back(r);
    r.item = make_item(OP_DIV, K_REG, 0, K_REG, 2);           directed_rows.push_back(r);
    r.item = make_item(OP_MOV, K_ADDR, 252, K_REG, 0);        directed_rows.push_back(r);
    r.item = make_item(OP_MOV, K_REG, 3, K_ADDR, 252);        directed_rows.push_back(r);
    r.item = make_item(OP_DIV, K_REG, 2, K_REG, 0);           directed_rows.push_back(r);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].has_fixed, directed_rows[i].fixed);
      idle_sender();
    end

    // Random phases; the last ends with an exit, then halted traffic.
    for (phase = 0; phase < 8; phase++) begin
      wait_drained();
      tx_gap_max = (phase % 3 == 0) ? 0 : 14;
      rx_gap_max = (phase % 3 == 1) ? 0 : 14;
      if (phase == 2) hold_off_rx = 1'b1;
      for (n = 0; n < 150; n++) begin
        send_item(random_instruction(), 1'b0, none);
        if (tx_gap_max != 0) idle_sender();
      end
      if (phase == 7) begin
        send_item(make_item(OP_EXIT, K_CONST, 31'($urandom_range(1, 0)), K_REG, 0),
                  1'b0, none);
        for (n = 0; n < 20; n++) send_item(random_instruction(), 1'b0, none);
        halt_count++;
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    stim_done = 1'b1;
    repeat (60) @(posedge clk);
    $display("Checked %0d results, %0d divides, %0d runs to exit with halted traffic.",
             result_count, div_count, halt_count);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
